>>> hdl/csv_field_splitter_macros.svh
// Assertion macros shared by the CSV field splitter RTL.
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define CSVFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define CSVFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/csvfs_pkg.sv
// Shared types, constants and helpers of the CSV field splitter.
package csvfs_pkg;

  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] COMMA_CH = 8'h2C;
  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] TAB_CH   = 8'h09;
  localparam logic [7:0] CR_CH    = 8'h0D;

  localparam int POS_W = 7;
  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic             emit;
    logic             line_end;
    logic [7:0]       idx;
    logic [CNT_W-1:0] total;
    logic             too_few;
    logic             trunc;
    logic             quoted;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic wr_bank;
    logic rd_bank;
  } qstat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == SPACE_CH) || ((c >= TAB_CH) && (c <= CR_CH));
  endfunction

endpackage

>>> hdl/csvfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csvfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/csvfs_front.sv
// Front end: takes line beats, tracks quotes, stores field bytes, issues field commands.
module csvfs_front #(
  parameter int FIELD_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_kind,
  input  logic [7:0]          field_limit,
  input  csvfs_pkg::qstat_t   qstat,
  output logic                push,
  output csvfs_pkg::cmd_t     push_cmd,
  output logic                wr_en,
  output logic [((FIELD_LEN > 1) ? $clog2(FIELD_LEN) : 1):0] wr_addr,
  output logic [7:0]          wr_data
);

  import csvfs_pkg::*;

  localparam int AW = (FIELD_LEN > 1) ? $clog2(FIELD_LEN) : 1;
  localparam logic [POS_W-1:0] LEN = POS_W'(FIELD_LEN);

  logic [POS_W-1:0] fill, fill_next;
  logic             quoting, quoting_next;
  logic             quote_pending, quote_pending_next;
  logic             overflow, overflow_next;
  logic [CNT_W-1:0] counted, counted_next;
  logic [7:0]       emitted, emitted_next;
  logic             has_nws, has_nws_next;
  logic [POS_W-1:0] first_pos, first_pos_next;
  logic [POS_W-1:0] last_pos, last_pos_next;
  logic [7:0]       first_ch, first_ch_next;
  logic [7:0]       last_ch, last_ch_next;

  logic             accept;
  logic             do_store;
  logic             do_finish;
  logic             line_end;
  logic             iq;
  logic [CNT_W-1:0] counted_inc;
  logic             emit;
  logic             quoted;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;

  assign counted_inc = (counted != CNT_MAX) ? counted + 1'b1 : counted;
  assign emit        = emitted < field_limit;
  assign quoted      = has_nws && (first_ch == QUOTE_CH) && (last_ch == QUOTE_CH);

  always_comb begin
    push_cmd.emit     = emit;
    push_cmd.line_end = line_end;
    push_cmd.idx      = emit ? emitted : 8'd0;
    push_cmd.total    = counted_inc;
    push_cmd.too_few  = line_end && (field_limit != 8'd0) &&
                        (counted_inc < {{(CNT_W-8){1'b0}}, field_limit});
    push_cmd.trunc    = emit && overflow;
    push_cmd.quoted   = quoted;
    if (!has_nws) begin
      push_cmd.s = '0;
      push_cmd.e = '0;
    end else if (quoted) begin
      push_cmd.s = first_pos + 1'b1;
      push_cmd.e = last_pos;
    end else begin
      push_cmd.s = first_pos;
      push_cmd.e = last_pos + 1'b1;
    end
  end

  always_comb begin
    fill_next          = fill;
    quoting_next       = quoting;
    quote_pending_next = quote_pending;
    overflow_next      = overflow;
    counted_next       = counted;
    emitted_next       = emitted;
    has_nws_next       = has_nws;
    first_pos_next     = first_pos;
    last_pos_next      = last_pos;
    first_ch_next      = first_ch;
    last_ch_next       = last_ch;
    do_store           = 1'b0;
    do_finish          = 1'b0;
    line_end           = 1'b0;
    iq                 = quoting;
    push               = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = {qstat.wr_bank, fill[AW-1:0]};
    wr_data            = s_tdata;

    if (accept) begin
      if (s_kind) begin
        do_finish = 1'b1;
        line_end  = 1'b1;
      end else if (quote_pending && (s_tdata == QUOTE_CH)) begin
        quote_pending_next = 1'b0;
        do_store           = 1'b1;
      end else begin
        iq                 = quote_pending ? 1'b0 : quoting;
        quote_pending_next = 1'b0;
        quoting_next       = iq;
        if (s_tdata == QUOTE_CH) begin
          if (iq) begin
            quote_pending_next = 1'b1;
          end else begin
            quoting_next = 1'b1;
          end
          do_store = 1'b1;
        end else if ((s_tdata == COMMA_CH) && !iq) begin
          do_finish = 1'b1;
        end else begin
          do_store = 1'b1;
        end
      end
    end

    if (do_store) begin
      if (fill < LEN) begin
        wr_en     = 1'b1;
        fill_next = fill + 1'b1;
        if (!is_ws(s_tdata)) begin
          if (!has_nws) begin
            has_nws_next   = 1'b1;
            first_pos_next = fill;
            first_ch_next  = s_tdata;
          end
          last_pos_next = fill;
          last_ch_next  = s_tdata;
        end
      end else begin
        overflow_next = 1'b1;
      end
    end

    if (do_finish) begin
      push               = emit || line_end;
      fill_next          = '0;
      overflow_next      = 1'b0;
      quoting_next       = 1'b0;
      quote_pending_next = 1'b0;
      has_nws_next       = 1'b0;
      if (line_end) begin
        counted_next = '0;
        emitted_next = '0;
      end else begin
        counted_next = counted_inc;
        emitted_next = emit ? emitted + 1'b1 : emitted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      quoting       <= 1'b0;
      quote_pending <= 1'b0;
      overflow      <= 1'b0;
      counted       <= '0;
      emitted       <= '0;
      has_nws       <= 1'b0;
    end else begin
      fill          <= fill_next;
      quoting       <= quoting_next;
      quote_pending <= quote_pending_next;
      overflow      <= overflow_next;
      counted       <= counted_next;
      emitted       <= emitted_next;
      has_nws       <= has_nws_next;
    end
  end

  always_ff @(posedge clk) begin
    first_pos <= first_pos_next;
    last_pos  <= last_pos_next;
    first_ch  <= first_ch_next;
    last_ch   <= last_ch_next;
  end

endmodule

>>> hdl/csvfs_cmd_queue.sv
// Two-entry command queue; its slot pointers also select the store bank.
module csvfs_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvfs_pkg::cmd_t   push_cmd,
  input  logic              pop,
  output csvfs_pkg::cmd_t   head,
  output csvfs_pkg::qstat_t qstat
);

  import csvfs_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;

  assign head          = slots[rd_ptr];
  assign qstat.full    = count == 2'd2;
  assign qstat.empty   = count == 2'd0;
  assign qstat.wr_bank = wr_ptr;
  assign qstat.rd_bank = rd_ptr;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hdl/csvfs_back.sv
// Back end: reads a finished field from the store, unescapes quotes, drives result beats.
module csvfs_back #(
  parameter int FIELD_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  csvfs_pkg::cmd_t   head,
  input  csvfs_pkg::qstat_t qstat,
  output logic              pop,
  output logic              rd_en,
  output logic [((FIELD_LEN > 1) ? $clog2(FIELD_LEN) : 1):0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);

  import csvfs_pkg::*;

  localparam int AW = (FIELD_LEN > 1) ? $clog2(FIELD_LEN) : 1;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_START = 4'b0010,
    B_CHAR  = 4'b0100,
    B_PEEK  = 4'b1000
  } bstate_t;

  bstate_t          state, state_next;
  logic [POS_W-1:0] p, p_next;
  logic [POS_W-1:0] p1, p2, nxt;
  logic             out_free;
  logic             load;
  logic             lst;

  logic [7:0]       ld_idx;
  logic [7:0]       ld_char;
  logic             ld_has;
  logic             ld_last;
  logic             ld_done;
  logic             ld_few;
  logic             ld_trunc;

  logic [7:0]       o_idx;
  logic [7:0]       o_char;
  logic             o_has;
  logic             o_last;
  logic             o_done;
  logic [CNT_W-1:0] o_total;
  logic             o_few;
  logic             o_trunc;

  assign p1       = p + 1'b1;
  assign p2       = p + 2'd2;
  assign nxt      = (rd_data == QUOTE_CH) ? p2 : p1;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    p_next     = p;
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {qstat.rd_bank, p[AW-1:0]};
    load       = 1'b0;
    lst        = 1'b0;
    ld_idx     = head.idx;
    ld_char    = rd_data;
    ld_has     = 1'b1;
    ld_last    = 1'b0;
    ld_done    = 1'b0;
    ld_few     = 1'b0;
    ld_trunc   = head.trunc;

    unique case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          p_next     = head.s;
          state_next = B_START;
        end
      end
      B_START: begin
        if (!head.emit || (p >= head.e)) begin
          if (out_free) begin
            load       = 1'b1;
            ld_char    = 8'd0;
            ld_has     = 1'b0;
            ld_last    = 1'b1;
            ld_done    = head.line_end;
            ld_few     = head.too_few;
            pop        = 1'b1;
            state_next = B_IDLE;
          end
        end else begin
          rd_en      = 1'b1;
          state_next = B_CHAR;
        end
      end
      B_CHAR: begin
        if (head.quoted && (rd_data == QUOTE_CH) && (p1 < head.e)) begin
          rd_en      = 1'b1;
          rd_addr    = {qstat.rd_bank, p1[AW-1:0]};
          state_next = B_PEEK;
        end else if (out_free) begin
          lst     = p1 >= head.e;
          load    = 1'b1;
          ld_last = lst;
          ld_done = lst && head.line_end;
          ld_few  = lst && head.too_few;
          p_next  = p1;
          if (lst) begin
            pop        = 1'b1;
            state_next = B_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = {qstat.rd_bank, p1[AW-1:0]};
          end
        end
      end
      B_PEEK: begin
        if (out_free) begin
          lst     = nxt >= head.e;
          load    = 1'b1;
          ld_char = QUOTE_CH;
          ld_last = lst;
          ld_done = lst && head.line_end;
          ld_few  = lst && head.too_few;
          p_next  = nxt;
          if (lst) begin
            pop        = 1'b1;
            state_next = B_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = {qstat.rd_bank, nxt[AW-1:0]};
            state_next = B_CHAR;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    if (load) begin
      o_idx   <= ld_idx;
      o_char  <= ld_char;
      o_has   <= ld_has;
      o_last  <= ld_last;
      o_done  <= ld_done;
      o_total <= head.total;
      o_few   <= ld_few;
      o_trunc <= ld_trunc;
    end
  end

  assign m_tdata = {3'b000, o_trunc, o_few, o_total, o_done, o_char, o_idx};
  assign m_tuser = o_has;
  assign m_tlast = o_last;

endmodule

>>> hdl/csv_field_splitter.sv
// Top level of the CSV field splitter: front end, command queue, store and back end.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: ch; tuser: kind
//  m_*      out  m_tvalid/m_tready    tdata: field_index..truncated; tuser: has_char;
//                                     tlast: last_of_field
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: field_limit
//
//  A line byte or end-of-line beat is taken whenever s_tready is high; the front end stalls only while
//  the command queue holds two finished fields.
//  A field passes B_IDLE to take its command and B_START to read its first byte, then gives
//  one beat per character while the output is free; a quote in a quoted field adds B_PEEK.
//  Reset is synchronous and clears all control state; the field store needs no clearing.
//  The result register holds a beat under back-pressure while the front end keeps taking bytes.
`include "csv_field_splitter_macros.svh"

module csv_field_splitter #(
  parameter int FIELD_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] field_index, [15:8] out_char, [16] line_done,
                                 // [26:17] total_fields, [27] too_few, [28] truncated
  output logic [0:0]  m_tuser,   // [0] has_char
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import csvfs_pkg::*;

  localparam int AW    = (FIELD_LEN > 1) ? $clog2(FIELD_LEN) : 1;
  localparam int DEPTH = 1 << (AW + 1);

  logic [7:0] field_limit;
  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head;
  qstat_t     qstat;
  logic       wr_en;
  logic [AW:0] wr_addr;
  logic [7:0] wr_data;
  logic       rd_en;
  logic [AW:0] rd_addr;
  logic [7:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_limit <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      field_limit <= cfg_data;
    end
  end

  csvfs_front #(
    .FIELD_LEN(FIELD_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_kind     (s_tuser[0]),
    .field_limit(field_limit),
    .qstat      (qstat),
    .push       (push),
    .push_cmd   (push_cmd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  csvfs_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .qstat   (qstat)
  );

  csvfs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  csvfs_back #(
    .FIELD_LEN(FIELD_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser[0]),
    .m_tlast (m_tlast)
  );

  `CSVFS_ASSERT_IMP(a_empty_is_single, m_tvalid && !m_tuser[0], m_tlast, "charless beat not last")
  `CSVFS_ASSERT_IMP(a_done_is_last, m_tvalid && m_tdata[16], m_tlast, "line_done beat not last")
  `CSVFS_ASSERT_IMP(a_few_needs_done, m_tvalid && m_tdata[27], m_tdata[16], "stray too_few")
  `CSVFS_ASSERT_IMP(a_read_has_cmd, rd_en, !qstat.empty, "store read with no queued field")

endmodule
